>>> hw/rtl/rcdq_pkg.sv
// Shared types, codes and tables for the run-length coefficient dequantizer.
`default_nettype none

package rcdq_pkg;

  localparam logic [1:0] MODE_RLE    = 2'd0;
  localparam logic [1:0] MODE_LUMA   = 2'd1;
  localparam logic [1:0] MODE_CHROMA = 2'd2;

  localparam logic [15:0] PAD_WORD   = 16'hFE00;
  localparam logic [6:0]  IDLE_POS   = 7'd64;
  localparam logic [6:0]  LAST_POS   = 7'd63;
  localparam logic [2:0]  MONO_BLKS  = 3'd1;
  localparam logic [2:0]  COLOR_BLKS = 3'd6;
  localparam logic [2:0]  FIRST_LUMA = 3'd2;

  localparam int unsigned TBL_DEPTH = 64;
  localparam int unsigned TBL_WIDTH = 8;

  localparam logic [5:0] ZIGZAG [64] = '{
     6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic load_out;
  } rcdq_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/rcdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rcdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/rcdq_ctrl.sv
// Sequencer: accept a word, step it through the two multiply stages, load the output.
`default_nettype none

module rcdq_ctrl
  import rcdq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      rcdq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    cmd_o        = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_one_word_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while another is in flight");

  a_fin_waits_for_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN && out_valid_q))
    else $error("result overwrote an undelivered word");

endmodule

`default_nettype wire

>>> hw/rtl/rcdq_datapath.sv
// Datapath: position and block tracking, quant tables, dequantize, round and clamp.
`default_nettype none

module rcdq_datapath
  import rcdq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rcdq_cmd_t   cmd_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] halfword_i,
  input  wire logic [5:0]  table_index_i,
  input  wire logic [7:0]  table_value_i,
  output      logic        coeff_write_o,
  output      logic [5:0]  coeff_index_o,
  output      logic signed [10:0] coeff_value_o,
  output      logic [2:0]  block_index_o,
  output      logic        block_start_o,
  output      logic        block_end_o,
  output      logic        macroblock_end_o
);

  localparam int unsigned AW = $clog2(TBL_DEPTH);

  // block state
  logic [1:0] depth_q;
  logic [6:0] pos_q, pos_d;
  logic [2:0] blk_q, blk_d;
  logic [5:0] scale_q, scale_d;

  // captured word
  logic              wr_q, wr_d;
  logic [5:0]        idx_q, idx_d;
  logic [2:0]        bidx_q;
  logic              bstart_q, bstart_d;
  logic              bend_q, bend_d;
  logic              mend_q, mend_d;
  logic signed [9:0] val_q, val_d;
  logic [5:0]        scl_q, scl_d;
  logic              ac_q, ac_d;
  logic              luma_q;

  // arithmetic stages
  logic signed [18:0] prod1_q;
  logic signed [25:0] pre_q;
  logic               div_q;

  // output word
  logic              out_wr_q;
  logic [5:0]        out_idx_q;
  logic signed [10:0] out_val_q;
  logic [2:0]        out_blk_q;
  logic              out_bstart_q;
  logic              out_bend_q;
  logic              out_mend_q;

  logic [5:0]          run;
  logic [6:0]          next_pos;
  logic [AW-1:0]       raddr;
  logic [TBL_WIDTH-1:0] luma_rd, chroma_rd, entry;
  logic [2:0]          blk_count;
  logic [3:0]          blk_inc;

  assign run       = halfword_i[15:10];
  assign next_pos  = pos_q + {1'b0, run} + 7'd1;
  assign blk_count = depth_q[1] ? COLOR_BLKS : MONO_BLKS;
  assign blk_inc   = {1'b0, blk_q} + 4'd1;

  always_comb begin
    pos_d    = pos_q;
    blk_d    = blk_q;
    scale_d  = scale_q;
    wr_d     = 1'b0;
    idx_d    = '0;
    bstart_d = 1'b0;
    bend_d   = 1'b0;
    mend_d   = 1'b0;
    val_d    = '0;
    scl_d    = scale_q;
    ac_d     = 1'b0;
    raddr    = '0;
    if (mode_i == MODE_RLE) begin
      if (pos_q >= IDLE_POS) begin
        bstart_d = 1'b1;
        // pad word leaves the block idle
        if (halfword_i != PAD_WORD) begin
          pos_d   = '0;
          scale_d = run;
          scl_d   = run;
          val_d   = $signed(halfword_i[9:0]);
          wr_d    = 1'b1;
        end
      end else if (next_pos >= LAST_POS) begin
        pos_d  = IDLE_POS;
        bend_d = 1'b1;
        if (blk_inc >= {1'b0, blk_count}) begin
          mend_d  = 1'b1;
          blk_d   = '0;
          scale_d = '0;
        end else begin
          blk_d = blk_inc[2:0];
        end
      end else begin
        pos_d = next_pos;
        val_d = $signed(halfword_i[9:0]);
        wr_d  = 1'b1;
        ac_d  = 1'b1;
        raddr = next_pos[AW-1:0];
        idx_d = (scale_q == '0) ? next_pos[5:0] : ZIGZAG[next_pos[5:0]];
      end
    end
  end

  rcdq_ram #(
    .WIDTH(TBL_WIDTH),
    .DEPTH(TBL_DEPTH)
  ) u_luma_tbl (
    .clk_i  (clk_i),
    .we_i   (cmd_i.capture && (mode_i == MODE_LUMA)),
    .waddr_i(table_index_i),
    .wdata_i(table_value_i),
    .raddr_i(raddr),
    .rdata_o(luma_rd)
  );

  rcdq_ram #(
    .WIDTH(TBL_WIDTH),
    .DEPTH(TBL_DEPTH)
  ) u_chroma_tbl (
    .clk_i  (clk_i),
    .we_i   (cmd_i.capture && (mode_i == MODE_CHROMA)),
    .waddr_i(table_index_i),
    .wdata_i(table_value_i),
    .raddr_i(raddr),
    .rdata_o(chroma_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      pos_q   <= IDLE_POS;
      blk_q   <= '0;
      scale_q <= '0;
    end else begin
      if (cfg_we_i) begin
        depth_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        pos_q   <= pos_d;
        blk_q   <= blk_d;
        scale_q <= scale_d;
      end
    end
  end

  assign entry = luma_q ? luma_rd : chroma_rd;

  logic signed [8:0]  factor;
  logic signed [25:0] prod2;
  logic signed [26:0] rnd, rnd_adj, quot, pre_ext, fin;
  logic signed [10:0] clamped;

  assign factor  = (scl_q == '0) ? 9'sd2 : $signed({1'b0, entry});
  assign prod2   = 26'(prod1_q) * 26'($signed({1'b0, scl_q}));
  assign rnd     = {pre_q[25], pre_q} + 27'sd4;
  // truncate toward zero: bias negative values before the shift
  assign rnd_adj = rnd + (rnd[26] ? 27'sd7 : 27'sd0);
  assign quot    = rnd_adj >>> 3;
  assign pre_ext = {pre_q[25], pre_q};
  assign fin     = div_q ? quot : pre_ext;

  always_comb begin
    if (fin < -27'sd1024) begin
      clamped = -11'sd1024;
    end else if (fin > 27'sd1023) begin
      clamped = 11'sd1023;
    end else begin
      clamped = fin[10:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wr_q     <= wr_d;
      idx_q    <= idx_d;
      bidx_q   <= blk_q;
      bstart_q <= bstart_d;
      bend_q   <= bend_d;
      mend_q   <= mend_d;
      val_q    <= val_d;
      scl_q    <= scl_d;
      ac_q     <= ac_d;
      luma_q   <= (blk_q >= FIRST_LUMA);
    end
    if (cmd_i.mul1) begin
      prod1_q <= 19'(val_q) * 19'(factor);
    end
    if (cmd_i.mul2) begin
      if (ac_q && (scl_q != '0)) begin
        pre_q <= prod2;
        div_q <= 1'b1;
      end else begin
        pre_q <= 26'(prod1_q);
        div_q <= 1'b0;
      end
    end
    if (cmd_i.load_out) begin
      out_wr_q     <= wr_q;
      out_idx_q    <= idx_q;
      out_val_q    <= wr_q ? clamped : 11'sd0;
      out_blk_q    <= bidx_q;
      out_bstart_q <= bstart_q;
      out_bend_q   <= bend_q;
      out_mend_q   <= mend_q;
    end
  end

  assign coeff_write_o    = out_wr_q;
  assign coeff_index_o    = out_idx_q;
  assign coeff_value_o    = out_val_q;
  assign block_index_o    = out_blk_q;
  assign block_start_o    = out_bstart_q;
  assign block_end_o      = out_bend_q;
  assign macroblock_end_o = out_mend_q;

  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q < LAST_POS) || (pos_q == IDLE_POS))
    else $error("coefficient position out of range");

  a_blk_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_q < COLOR_BLKS)
    else $error("block counter past last block");

  a_end_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture && bend_d) |=> (!wr_q && pos_q == IDLE_POS))
    else $error("block end wrote a coefficient or left the block active");

endmodule

`default_nettype wire

>>> hw/rtl/rle_coefficient_dequantizer.sv
// Top level of the run-length coefficient decoder and dequantizer.
//
// Input channel (in_valid_i/in_ready_o) takes one word per handshake: mode 0
// carries a run-length halfword, mode 1 and 2 write one entry of the luma or
// chroma quantizer table. Every accepted word yields exactly one result word
// on the output channel (out_valid_o/out_ready_i): a coefficient write, or a
// status-only word for table writes, mode 3 words, pad words and block ends.
// The config channel (cfg_valid_i/cfg_ready_o) sets the output depth; it is
// always ready. It must be written only while the block is idle; the block
// itself does not enforce this. After acceptance a word passes table read,
// table multiply, scale multiply, then round and clamp into the result
// register. One word is in flight at a time, so the input takes no new word
// until the result of the last one is loaded; the next word is taken while a
// finished result still waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// sequencer holds its finished word until that register drains.
// Reset puts the block idle awaiting a block start, block counter and scale
// at zero, depth at mono 4-bit. Quant tables are undefined until written.
`default_nettype none

module rle_coefficient_dequantizer
  import rcdq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] halfword_i,
  input  wire logic [5:0]  table_index_i,
  input  wire logic [7:0]  table_value_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        coeff_write_o,
  output      logic [5:0]  coeff_index_o,
  output      logic signed [10:0] coeff_value_o,
  output      logic [2:0]  block_index_o,
  output      logic        block_start_o,
  output      logic        block_end_o,
  output      logic        macroblock_end_o
);

  rcdq_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  rcdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  rcdq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .halfword_i      (halfword_i),
    .table_index_i   (table_index_i),
    .table_value_i   (table_value_i),
    .coeff_write_o   (coeff_write_o),
    .coeff_index_o   (coeff_index_o),
    .coeff_value_o   (coeff_value_o),
    .block_index_o   (block_index_o),
    .block_start_o   (block_start_o),
    .block_end_o     (block_end_o),
    .macroblock_end_o(macroblock_end_o)
  );

endmodule

`default_nettype wire

>>> verif/tb_rle_coefficient_dequantizer.sv
// Self-checking testbench for the run-length coefficient dequantizer.
`timescale 1ns / 1ps

module tb_rle_coefficient_dequantizer;
  import rcdq_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] DEPTH_MONO4 = 2'd0;
  localparam logic [1:0] DEPTH_MONO8 = 2'd1;
  localparam logic [1:0] DEPTH_RGB24 = 2'd2;
  localparam logic [1:0] DEPTH_RGB15 = 2'd3;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  // raster position for each zigzag step
  localparam logic [5:0] ZZ_RASTER [64] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] halfword;
    logic [5:0]  table_index;
    logic [7:0]  table_value;
  } rle_word_t;

  typedef struct packed {
    logic        coeff_write;
    logic [5:0]  coeff_index;
    logic [10:0] coeff_value;
    logic [2:0]  block_index;
    logic        block_start;
    logic        block_end;
    logic        macroblock_end;
  } coeff_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [15:0] halfword_i = '0;
  logic [5:0]  table_index_i = '0;
  logic [7:0]  table_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        coeff_write_o;
  logic [5:0]  coeff_index_o;
  logic signed [10:0] coeff_value_o;
  logic [2:0]  block_index_o;
  logic        block_start_o;
  logic        block_end_o;
  logic        macroblock_end_o;

  rle_coefficient_dequantizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .halfword_i       (halfword_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .coeff_write_o    (coeff_write_o),
    .coeff_index_o    (coeff_index_o),
    .coeff_value_o    (coeff_value_o),
    .block_index_o    (block_index_o),
    .block_start_o    (block_start_o),
    .block_end_o      (block_end_o),
    .macroblock_end_o (macroblock_end_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the block state
  logic [1:0] depth_q = DEPTH_MONO4;
  logic [6:0] pos_q = IDLE_POS;
  logic [2:0] blk_cnt_q = '0;
  logic [5:0] scale_q = '0;
  logic [7:0] luma_tbl [64];
  logic [7:0] chroma_tbl [64];

  rle_word_t     pending_words [$];
  coeff_result_t expected_coeffs [$];
  rle_word_t     offered_word;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_built = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int cycle_count = 0;

  function automatic logic [7:0] quant_entry(input int idx);
    return (blk_cnt_q >= FIRST_LUMA) ? luma_tbl[idx & 63] : chroma_tbl[idx & 63];
  endfunction

  function automatic coeff_result_t dequantize_word(input rle_word_t w);
    coeff_result_t r;
    int v;
    int p;
    logic [2:0] blocks;
    r = '0;
    v = 0;
    r.block_index = blk_cnt_q;
    case (w.mode)
      MODE_LUMA:   luma_tbl[w.table_index] = w.table_value;
      MODE_CHROMA: chroma_tbl[w.table_index] = w.table_value;
      MODE_RLE: begin
        v = int'(w.halfword[8:0]) - (w.halfword[9] ? 512 : 0);
        if (pos_q >= IDLE_POS) begin
          r.block_start = 1'b1;
          // pad word keeps the block idle
          if (w.halfword != PAD_WORD) begin
            pos_q = '0;
            scale_q = w.halfword[15:10];
            if (scale_q == 0) v = v * 2;
            else v = v * int'(quant_entry(0));
            r.coeff_index = ZZ_RASTER[0];
            r.coeff_write = 1'b1;
          end
        end else begin
          p = int'(pos_q) + int'(w.halfword[15:10]) + 1;
          if (p >= int'(LAST_POS)) begin
            // depth bit 1 selects the six-block colour macroblock
            blocks = depth_q[1] ? COLOR_BLKS : MONO_BLKS;
            pos_q = IDLE_POS;
            r.block_end = 1'b1;
            if (int'(blk_cnt_q) + 1 >= int'(blocks)) begin
              r.macroblock_end = 1'b1;
              blk_cnt_q = '0;
              scale_q = '0;
            end else begin
              blk_cnt_q = blk_cnt_q + 3'd1;
            end
          end else begin
            pos_q = p[6:0];
            if (scale_q == 0) begin
              v = v * 2;
              r.coeff_index = p[5:0];
            end else begin
              v = v * int'(quant_entry(p)) * int'(scale_q);
              v = (v + 4) / 8;
              r.coeff_index = ZZ_RASTER[p];
            end
            r.coeff_write = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (r.coeff_write) begin
      if (v < -1024) v = -1024;
      else if (v > 1023) v = 1023;
      r.coeff_value = v[10:0];
    end
    return r;
  endfunction

  function automatic void queue_word(input logic [1:0] m, input logic [15:0] hw,
                                     input logic [5:0] ti, input logic [7:0] tv);
    rle_word_t w;
    w.mode = m;
    w.halfword = hw;
    w.table_index = ti;
    w.table_value = tv;
    pending_words = {pending_words, w};
    if (m != MODE_UNUSED) words_built++;
  endfunction

  function automatic void queue_rle(input logic [5:0] run, input logic [9:0] value);
    queue_word(MODE_RLE, {run, value}, 6'($urandom), 8'($urandom));
  endfunction

  function automatic logic [9:0] pick_value();
    case ($urandom_range(7))
      0: return 10'h1FF;
      1: return 10'h200;
      2: return 10'($urandom_range(8)) - 10'd4;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  // one well-formed block: start word, a few AC words, then a terminating run
  function automatic void queue_block();
    logic [5:0] scale;
    logic [9:0] value;
    int pos;
    int run;
    int n;
    case ($urandom_range(5))
      0: scale = 6'd0;
      1: scale = 6'd63;
      default: scale = 6'($urandom_range(1, 63));
    endcase
    do value = pick_value(); while ({scale, value} == PAD_WORD);
    queue_rle(scale, value);
    pos = 0;
    n = $urandom_range(12);
    for (int i = 0; i < n; i++) begin
      if (pos > 61) break;
      if ($urandom_range(3) == 0) run = $urandom_range(61 - pos);
      else run = $urandom_range((61 - pos < 4) ? 61 - pos : 4);
      queue_rle(6'(run), pick_value());
      pos = pos + run + 1;
    end
    queue_rle(6'($urandom_range(63, 62 - pos)), pick_value());
  endfunction

  task automatic queue_random_words(input int n);
    int first;
    first = words_built;
    while (words_built - first < n) begin
      case ($urandom_range(19))
        0: queue_word(MODE_LUMA, 16'($urandom), 6'($urandom), 8'($urandom));
        1: queue_word(MODE_CHROMA, 16'($urandom), 6'($urandom), 8'($urandom));
        2: queue_word(MODE_UNUSED, 16'($urandom), 6'($urandom), 8'($urandom));
        3: queue_word(MODE_RLE, PAD_WORD, 6'($urandom), 8'($urandom));
        4: queue_word(MODE_RLE, 16'($urandom), 6'($urandom), 8'($urandom));
        default: queue_block();
      endcase
    end
  endtask

  task automatic queue_directed();
    queue_word(MODE_LUMA, 16'h0000, 6'd0, 8'd255);
    queue_word(MODE_CHROMA, 16'hFFFF, 6'd63, 8'd0);
    queue_word(MODE_CHROMA, 16'h0000, 6'd0, 8'd255);
    queue_word(MODE_CHROMA, 16'h0000, 6'd1, 8'd255);
    queue_word(MODE_CHROMA, 16'h0000, 6'd2, 8'd0);
    queue_word(MODE_UNUSED, 16'hFFFF, 6'h3F, 8'hFF);
    // pad while idle, then a zero-scale block walking to the last position
    queue_word(MODE_RLE, PAD_WORD, 6'd0, 8'd0);
    queue_rle(6'd0, 10'h200);
    queue_rle(6'd0, 10'h1FF);
    queue_rle(6'd60, 10'h200);
    queue_rle(6'd0, 10'h000);
    // full scale: clamp both ways, zero table entry, rounding of -1
    queue_rle(6'd63, 10'h1FF);
    queue_rle(6'd0, 10'h200);
    queue_rle(6'd0, 10'h001);
    queue_rle(6'd0, 10'h3FF);
    queue_word(MODE_RLE, PAD_WORD, 6'd0, 8'd0);
    queue_rle(6'd1, 10'h001);
    queue_rle(6'h3F, 10'h3FF);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_coeffs.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_output_depth(input logic [1:0] depth);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= depth;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    depth_q = depth;
  endtask

  task automatic run_phase(input logic [1:0] depth, input int send_pct, input int recv_pct,
                           input int n);
    wait_drained();
    set_output_depth(depth);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_random_words(n);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_output_depth(DEPTH_MONO4);
    send_idle_pct = 37;
    recv_idle_pct = 53;
    // fill both tables so no entry is read before it is written
    for (int i = 0; i < 64; i++) begin
      queue_word(MODE_LUMA, 16'($urandom), 6'(i), 8'($urandom));
      queue_word(MODE_CHROMA, 16'($urandom), 6'(i), 8'($urandom));
    end
    queue_directed();
    queue_random_words(330);
    run_phase(DEPTH_RGB15, 37, 53, 330);
    run_phase(DEPTH_MONO8, 53, 37, 330);
    run_phase(DEPTH_RGB24, 53, 37, 330);
    run_phase(DEPTH_MONO4, 0, 0, 330);
    run_phase(DEPTH_RGB15, 0, 0, 330);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // driver: offer the next pending word, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_coeffs = {expected_coeffs, dequantize_word(offered_word)};
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_word = pending_words[0];
          pending_words.delete(0);
          in_valid_i    <= 1'b1;
          mode_i        <= offered_word.mode;
          halfword_i    <= offered_word.halfword;
          table_index_i <= offered_word.table_index;
          table_value_i <= offered_word.table_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    coeff_result_t got;
    coeff_result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.coeff_write    = coeff_write_o;
        got.coeff_index    = coeff_index_o;
        got.coeff_value    = coeff_value_o;
        got.block_index    = block_index_o;
        got.block_start    = block_start_o;
        got.block_end      = block_end_o;
        got.macroblock_end = macroblock_end_o;
        if (expected_coeffs.size() == 0) begin
          if (mismatch_count < 10)
            $display("ERROR: unexpected result word at cycle %0d", cycle_count);
          mismatch_count++;
        end else begin
          exp_r = expected_coeffs[0];
          expected_coeffs.delete(0);
          if (got !== exp_r) begin
            if (mismatch_count < 10)
              $display({"ERROR: word %0d exp wr=%0d idx=%0d val=%0d blk=%0d st=%0d ",
                        "end=%0d mend=%0d, got wr=%0d idx=%0d val=%0d blk=%0d st=%0d ",
                        "end=%0d mend=%0d"}, results_checked,
                       exp_r.coeff_write, exp_r.coeff_index, $signed(exp_r.coeff_value),
                       exp_r.block_index, exp_r.block_start, exp_r.block_end,
                       exp_r.macroblock_end, got.coeff_write, got.coeff_index,
                       $signed(got.coeff_value), got.block_index, got.block_start,
                       got.block_end, got.macroblock_end);
            mismatch_count++;
          end
        end
        results_checked++;
      end
      // one long hold-off to back the block up into its input
      if (!long_hold_done && results_checked >= 400) begin
        hold_left = 300;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
